// ----- design/fpss_pkg.sv -----
// ----------------------------------------------------------------------------
// fpss_pkg
// shared types and constants of the fixed point to seven segment unit
// ----------------------------------------------------------------------------
package fpss_pkg;

   localparam int NUM_POS    = 6;   // display positions
   localparam int NUM_STAGES = 7;   // pipeline registers, input to output
   localparam int VALUE_W    = 31;
   localparam int MAG_W      = 20;  // magnitude of any accepted value
   localparam int HALF_W     = 10;  // three-digit group, 0..999
   localparam int SEG_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   typedef logic [3:0]        digit_type;
   typedef logic [SEG_W-1:0]  seg_type;
   typedef logic [1:0]        dp_type;

   // register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DECIMAL_PLACES = 1'b0,
      CSR_POINT_MASK     = 1'b1
   } csr_index_type;

   // per-word status carried alongside the digits
   typedef struct packed {
      logic rejected;
      logic negative;
   } flag_type;

   localparam dp_type  DP_RESET   = 2'd3;
   localparam seg_type MASK_RESET = 8'h04;
   localparam seg_type SEG_MINUS  = 8'h10;
   localparam seg_type SEG_BLANK  = 8'h00;

   // segment pattern of one decimal digit
   function automatic seg_type seg_of(input digit_type d);
      seg_type s;
      case (d)
         4'd0:    s = 8'hEB;
         4'd1:    s = 8'h88;
         4'd2:    s = 8'hB3;
         4'd3:    s = 8'hBA;
         4'd4:    s = 8'hD8;
         4'd5:    s = 8'h7A;
         4'd6:    s = 8'h7B;
         4'd7:    s = 8'hA8;
         4'd8:    s = 8'hFB;
         4'd9:    s = 8'hFA;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

// ----- design/fpss_if.sv -----
// ----------------------------------------------------------------------------
// fpss_req_if / fpss_rsp_if
// valid/ready channels of the fixed point to seven segment unit
// ----------------------------------------------------------------------------
interface fpss_req_if import fpss_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  scaled_value;

   modport source (output valid, output scaled_value, input ready);
   modport sink   (input valid, input scaled_value, output ready);
endinterface

interface fpss_rsp_if import fpss_pkg::*; ();
   logic          valid;
   logic          ready;
   seg_type       grid0;
   seg_type       grid1;
   seg_type       grid2;
   seg_type       grid3;
   seg_type       grid4;
   seg_type       grid5;
   logic          shown;

   modport source (output valid, output grid0, output grid1, output grid2,
                   output grid3, output grid4, output grid5, output shown,
                   input ready);
   modport sink   (input valid, input grid0, input grid1, input grid2,
                   input grid3, input grid4, input grid5, input shown,
                   output ready);
endinterface

// ----- design/fpss_split.sv -----
// ----------------------------------------------------------------------------
// fpss_split
// range check, sign and magnitude, split into two three-digit groups
// ----------------------------------------------------------------------------
module fpss_split import fpss_pkg::*; (
   input  logic                      clock,
   input  logic [2:0]                en,          // stage enables, first stage in bit 0
   input  logic signed [VALUE_W-1:0] value,
   output flag_type                  flags,
   output logic [HALF_W-1:0]         hi,
   output logic [HALF_W-1:0]         lo
);

   localparam logic signed [VALUE_W-1:0] LIMIT_HIGH = 31'sd999999;
   localparam logic signed [VALUE_W-1:0] LIMIT_LOW  = -31'sd99999;
   // 2^30 / 1000 rounded up, exact for magnitudes below one million
   localparam int          RECIP_W    = 21;
   localparam int          RECIP_SH   = 30;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742;
   localparam logic [MAG_W-1:0]   THOUSAND   = 20'd1000;

   flag_type                   flags1_in, flags1_ff, flags2_ff, flags3_ff;
   logic [MAG_W-1:0]           mag1_in, mag1_ff, mag2_ff;
   logic [VALUE_W-1:0]         neg_value;
   logic [MAG_W+RECIP_W-1:0]   product;
   logic [HALF_W-1:0]          hi2_in, hi2_ff, hi3_ff, lo3_in, lo3_ff;
   logic [MAG_W-1:0]           hi_scaled, lo_wide;

   // stage 1: range and magnitude
   always_comb begin
      flags1_in.rejected = (value >= LIMIT_HIGH) || (value <= LIMIT_LOW);
      flags1_in.negative = value[VALUE_W-1];
      neg_value          = VALUE_W'(-value);
      mag1_in            = flags1_in.negative ? neg_value[MAG_W-1:0]
                                              : value[MAG_W-1:0];
   end

   // stage 2: upper group by reciprocal multiply
   assign product = {{RECIP_W{1'b0}}, mag1_ff} * {{MAG_W{1'b0}}, RECIP_1000};
   assign hi2_in  = product[RECIP_SH +: HALF_W];

   // stage 3: lower group as remainder
   assign hi_scaled = {{(MAG_W-HALF_W){1'b0}}, hi2_ff} * THOUSAND;
   assign lo_wide   = mag2_ff - hi_scaled;
   assign lo3_in    = lo_wide[HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         flags1_ff <= flags1_in;
         mag1_ff   <= mag1_in;
      end
      if (en[1]) begin
         flags2_ff <= flags1_ff;
         mag2_ff   <= mag1_ff;
         hi2_ff    <= hi2_in;
      end
      if (en[2]) begin
         flags3_ff <= flags2_ff;
         hi3_ff    <= hi2_ff;
         lo3_ff    <= lo3_in;
      end
   end

   assign flags = flags3_ff;
   assign hi    = hi3_ff;
   assign lo    = lo3_ff;

endmodule

// ----- design/fpss_digits.sv -----
// ----------------------------------------------------------------------------
// fpss_digits
// two-stage split of a value 0..999 into hundreds, tens and units
// ----------------------------------------------------------------------------
module fpss_digits import fpss_pkg::*; (
   input  logic              clock,
   input  logic [1:0]        en,
   input  logic [HALF_W-1:0] value,
   output digit_type [2:0]   digits      // [2] hundreds, [0] units
);

   logic [15:0]       hund_prod;
   digit_type         hund_in, hund_ff;
   logic [HALF_W-1:0] hund_scaled, rem_wide;
   logic [6:0]        rem_in, rem_ff;
   logic [13:0]       tens_prod;
   digit_type         tens_in;
   logic [6:0]        tens_scaled, units_wide;
   digit_type [2:0]   digits_in, digits_ff;

   // x / 100 as (x * 41) >> 12, exact below 1000
   assign hund_prod   = {6'b0, value} * 16'd41;
   assign hund_in     = hund_prod[15:12];
   assign hund_scaled = {6'b0, hund_in} * 10'd100;
   assign rem_wide    = value - hund_scaled;
   assign rem_in      = rem_wide[6:0];

   // r / 10 as (r * 103) >> 10, exact below 100
   assign tens_prod   = {7'b0, rem_ff} * 14'd103;
   assign tens_in     = tens_prod[13:10];
   assign tens_scaled = {3'b0, tens_in} * 7'd10;
   assign units_wide  = rem_ff - tens_scaled;
   assign digits_in   = {hund_ff, tens_in, units_wide[3:0]};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hund_ff <= hund_in;
         rem_ff  <= rem_in;
      end
      if (en[1]) begin
         digits_ff <= digits_in;
      end
   end

   assign digits = digits_ff;

endmodule

// ----- design/fpss_encode.sv -----
// ----------------------------------------------------------------------------
// fpss_encode
// blanking, point, minus placement and segment lookup into the result register
// ----------------------------------------------------------------------------
module fpss_encode import fpss_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  flag_type                flags,
   input  digit_type [NUM_POS-1:0] digits,    // index is the power of ten
   input  dp_type                  decimal_places,
   input  seg_type                 point_mask,
   output seg_type [NUM_POS-1:0]   grids,     // index is the power of ten
   output logic                    shown
);

   logic [NUM_POS-1:0]    drawn, minus_at;
   logic                  above;
   seg_type [NUM_POS-1:0] grids_in, grids_ff;
   logic                  shown_ff;

   always_comb begin
      // a position is drawn up to the units digit or under a nonzero digit
      above = 1'b0;
      for (int k = NUM_POS-1; k >= 0; k--) begin
         above    = above | (digits[k] != 4'd0);
         drawn[k] = above || ({1'b0, decimal_places} >= 3'(k));
      end
      // minus one left of the highest drawn digit, leftmost if full
      minus_at[0] = 1'b0;
      for (int k = 1; k < NUM_POS-1; k++) begin
         minus_at[k] = drawn[k-1] && !drawn[k];
      end
      minus_at[NUM_POS-1] = drawn[NUM_POS-2];

      for (int k = 0; k < NUM_POS; k++) begin
         if (flags.rejected) begin
            grids_in[k] = SEG_BLANK;
         end else if (flags.negative && minus_at[k]) begin
            grids_in[k] = SEG_MINUS;
         end else if (drawn[k]) begin
            grids_in[k] = seg_of(digits[k])
                        | (({1'b0, decimal_places} == 3'(k)) ? point_mask : SEG_BLANK);
         end else begin
            grids_in[k] = SEG_BLANK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         grids_ff <= grids_in;
         shown_ff <= !flags.rejected;
      end
   end

   assign grids = grids_ff;
   assign shown = shown_ff;

endmodule

// ----- design/fixed_point_to_seven_segment_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_point_to_seven_segment_unit
// signed scaled value to six seven-segment digit bytes
// ----------------------------------------------------------------------------
//   channel  dir  handshake        word
//   req      in   valid / ready    scaled_value
//   rsp      out  valid / ready    grid0..grid5, shown
//   csr      in   csr_write_en     csr_index, csr_write_data
//
// seven register stages from input to result; one item can be taken every
// cycle until a stalled rsp has filled the pipe
// the digits come from constant-divisor reciprocal multiplies, spread over
// stages 2 to 5
// every stage holds its word while the next one is full and stalled, so a stalled
// rsp fills the pipe before req.ready drops; bubbles are squeezed out
// reset clears the stage valid bits and loads decimal_places 3, point_mask 04
// ----------------------------------------------------------------------------
module fixed_point_to_seven_segment_unit import fpss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fpss_req_if.sink              req,
   fpss_rsp_if.source            rsp,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // configuration registers
   dp_type  decimal_places_ff;
   seg_type point_mask_ff;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] adv;          // stage may load this cycle

   // datapath
   logic signed [VALUE_W-1:0] value_ff;
   flag_type                  flags3, flags4_ff, flags5_ff;
   logic [HALF_W-1:0]         hi3, lo3;
   digit_type [2:0]           hi_digits, lo_digits;
   seg_type [NUM_POS-1:0]     grids;
   logic                      shown;

   // csr writes, expected only while the pipe is idle
   always_ff @(posedge clock) begin
      if (reset) begin
         decimal_places_ff <= DP_RESET;
         point_mask_ff     <= MASK_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DECIMAL_PLACES: decimal_places_ff <= csr_write_data[1:0];
            CSR_POINT_MASK:     point_mask_ff     <= csr_write_data;
            default:            ;
         endcase
      end
   end

   // a stage loads when empty or when the stage after it moves on
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int i = NUM_STAGES-2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign req.ready = adv[0];

   // stage 0: input register
   always_ff @(posedge clock) begin
      if (adv[0]) value_ff <= req.scaled_value;
   end

   // stages 1 to 3: range, magnitude, thousands split
   fpss_split u_split (
      .clock (clock),
      .en    (adv[3:1]),
      .value (value_ff),
      .flags (flags3),
      .hi    (hi3),
      .lo    (lo3)
   );

   // stages 4 and 5: decimal digits of each group
   fpss_digits u_digits_hi (
      .clock  (clock),
      .en     (adv[5:4]),
      .value  (hi3),
      .digits (hi_digits)
   );

   fpss_digits u_digits_lo (
      .clock  (clock),
      .en     (adv[5:4]),
      .value  (lo3),
      .digits (lo_digits)
   );

   // status follows the digits
   always_ff @(posedge clock) begin
      if (adv[4]) flags4_ff <= flags3;
      if (adv[5]) flags5_ff <= flags4_ff;
   end

   // stage 6: segment encoding into the result register
   fpss_encode u_encode (
      .clock          (clock),
      .en             (adv[6]),
      .flags          (flags5_ff),
      .digits         ({hi_digits, lo_digits}),
      .decimal_places (decimal_places_ff),
      .point_mask     (point_mask_ff),
      .grids          (grids),
      .shown          (shown)
   );

   // position k of the number goes to grid 5-k, so grid0 is the leftmost
   assign rsp.valid = valid_ff[NUM_STAGES-1];
   assign rsp.grid0 = grids[5];
   assign rsp.grid1 = grids[4];
   assign rsp.grid2 = grids[3];
   assign rsp.grid3 = grids[2];
   assign rsp.grid4 = grids[1];
   assign rsp.grid5 = grids[0];
   assign rsp.shown = shown;

endmodule

// ----- design/fpss_checker.sv -----
// ----------------------------------------------------------------------------
// fpss_checker
// port-level checks of the fixed point to seven segment unit
// ----------------------------------------------------------------------------
module fpss_checker import fpss_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input seg_type grid0,
   input seg_type grid5,
   input seg_type grid_mid1,
   input seg_type grid_mid2,
   input seg_type grid_mid3,
   input seg_type grid_mid4,
   input logic    rsp_shown
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(grid0) && $stable(grid5)
         && $stable(rsp_shown))
      else $error("result changed while stalled");

   // input is refused only when the output is stalled and the pipe is full
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without output stall");

   // a rejected value shows a blank display
   a_reject_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_shown |-> grid0 == SEG_BLANK && grid_mid1 == SEG_BLANK
         && grid_mid2 == SEG_BLANK && grid_mid3 == SEG_BLANK
         && grid_mid4 == SEG_BLANK && grid5 == SEG_BLANK)
      else $error("rejected value not blank");

   // rightmost digit always drawn, leftmost never a leading zero
   a_shown_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown |-> grid5 != SEG_BLANK && grid0 != seg_of(4'd0))
      else $error("bad edge digit");

endmodule

bind fixed_point_to_seven_segment_unit fpss_checker u_fpss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .grid0     (rsp.grid0),
   .grid5     (rsp.grid5),
   .grid_mid1 (rsp.grid1),
   .grid_mid2 (rsp.grid2),
   .grid_mid3 (rsp.grid3),
   .grid_mid4 (rsp.grid4),
   .rsp_shown (rsp.shown)
);

// ----- test/tb_fixed_point_to_seven_segment_unit.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_point_to_seven_segment_unit
// self-checking bench for the scaled value to seven segment display unit
// ----------------------------------------------------------------------------
// a queue of pending steps (words, register writes, drain points) feeds a
// clocked driver on the req channel; every accepted word is run through a
// local display predictor and the expected grids are queued; a clocked
// monitor on the rsp channel compares each result field by field with the
// oldest expectation; both sides idle in random bursts, none near the end
// ----------------------------------------------------------------------------
module tb_fixed_point_to_seven_segment_unit import fpss_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RESET_CYCLES = 7;
   localparam int     SETTLE       = NUM_STAGES + 2;  // idle edges before a write
   localparam int     LIMIT_CYCLES = 200000;
   localparam int     PHASES       = 10;
   localparam int     PHASE_WORDS  = 103;
   localparam longint SHOW_MAX     = 999999;   // at or above: rejected
   localparam longint SHOW_MIN     = -99999;   // at or below: rejected
   localparam longint VALUE_LIMIT  = 999999999;

   // segment patterns of the decimal digits 0..9
   localparam seg_type DIGIT_SEGS [10] = '{8'hEB, 8'h88, 8'hB3, 8'hBA, 8'hD8,
                                           8'h7A, 8'h7B, 8'hA8, 8'hFB, 8'hFA};

   typedef struct packed {
      seg_type grid0;
      seg_type grid1;
      seg_type grid2;
      seg_type grid3;
      seg_type grid4;
      seg_type grid5;
      logic    shown;
   } display_type;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_CSR,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type              kind;
      logic signed [VALUE_W-1:0]  value;
      csr_index_type              idx;
      logic [CSR_DATA_W-1:0]      data;
      logic                       calm;   // no idling on either side
   } step_type;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   fpss_req_if req_ch ();
   fpss_rsp_if rsp_ch ();

   fixed_point_to_seven_segment_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // bench copy of the two registers, follows every write we issue
   dp_type  cfg_places = DP_RESET;
   seg_type cfg_mask   = MASK_RESET;

   step_type    pending_steps [$];
   display_type expected_displays [$];

   int   words_sent  = 0;   // both counters move by nonblocking update only
   int   words_shown = 0;
   int   quiet       = 0;   // edges with nothing in flight
   int   send_gap    = 0;
   int   rsp_stall   = 0;
   int   cycles      = 0;
   logic calm        = 1'b0;
   logic failed      = 1'b0;

   always #6 clock = ~clock;

   // --------------------------------------------------------------------------
   // display predictor: scaled value and current registers to six grids
   // --------------------------------------------------------------------------
   function automatic display_type predict_display(input logic signed [VALUE_W-1:0] value,
                                                   input dp_type places,
                                                   input seg_type mask);
      display_type d;
      seg_type  digit_segs [NUM_POS];   // index k holds the digit of weight 10^k
      longint   s;
      longint   mag;
      int       dp;
      int       top;
      logic     neg;
      d   = '0;
      s   = value;
      dp  = places;
      top = -1;
      // out of range: nothing shown, all grids blank
      if (s >= SHOW_MAX || s <= SHOW_MIN)
         return d;
      neg = s < 0;
      mag = neg ? -s : s;
      for (int k = 0; k < NUM_POS; k++) begin
         // leading zeros above the units digit are blanked
         if (mag != 0 || k <= dp) begin
            digit_segs[k] = DIGIT_SEGS[mag % 10];
            if (k == dp)
               digit_segs[k] = digit_segs[k] | mask;
            mag = mag / 10;
            top = k;
         end else begin
            digit_segs[k] = SEG_BLANK;
         end
      end
      // minus sits one left of the highest drawn digit, or over it when full
      if (neg) begin
         if (top < NUM_POS - 1)
            digit_segs[top + 1] = SEG_MINUS;
         else
            digit_segs[NUM_POS - 1] = SEG_MINUS;
      end
      d.grid0 = digit_segs[5];
      d.grid1 = digit_segs[4];
      d.grid2 = digit_segs[3];
      d.grid3 = digit_segs[2];
      d.grid4 = digit_segs[1];
      d.grid5 = digit_segs[0];
      d.shown = 1'b1;
      return d;
   endfunction

   // mostly displayable values of random length, some near the limits, some wild
   function automatic int random_scaled();
      int lim;
      int mag;
      int v;
      lim = 1;
      case ($urandom_range(0, 9))
         0: v = int'($urandom_range(0, 32'(2 * VALUE_LIMIT))) - int'(VALUE_LIMIT);
         1: begin
            case ($urandom_range(0, 1))
               0: v = int'(SHOW_MAX) - 3 + int'($urandom_range(0, 6));
               default: v = int'(SHOW_MIN) - 3 + int'($urandom_range(0, 6));
            endcase
         end
         default: begin
            repeat ($urandom_range(1, 6)) lim = lim * 10;
            mag = $urandom_range(0, lim - 1);
            v   = $urandom_range(0, 2) == 0 ? -mag : mag;
         end
      endcase
      return v;
   endfunction

   task automatic push_word(input int value, input logic quiet_run);
      step_type st;
      st.kind  = STEP_WORD;
      st.value = VALUE_W'(value);
      st.idx   = CSR_DECIMAL_PLACES;
      st.data  = '0;
      st.calm  = quiet_run;
      pending_steps.push_back(st);
   endtask

   task automatic push_step(input step_kind_type kind, input csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      step_type st;
      st.kind  = kind;
      st.value = '0;
      st.idx   = idx;
      st.data  = data;
      st.calm  = 1'b0;
      pending_steps.push_back(st);
   endtask

   task automatic check_field(input string name, input logic [SEG_W-1:0] want,
                              input logic [SEG_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         failed = 1'b1;
      end
   endtask

   // --------------------------------------------------------------------------
   // driver: one step from the pending queue per free slot
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic                      nxt_valid;
      logic signed [VALUE_W-1:0] nxt_value;
      logic                      nxt_we;
      logic [CSR_IDX_W-1:0]      nxt_idx;
      logic [CSR_DATA_W-1:0]     nxt_wdata;
      logic                      took;
      step_type                  head;
      nxt_valid = req_ch.valid;
      nxt_value = req_ch.scaled_value;
      nxt_we    = 1'b0;
      nxt_idx   = csr_index;
      nxt_wdata = csr_write_data;
      took      = req_ch.valid && req_ch.ready;
      if (reset) begin
         nxt_valid = 1'b0;
         quiet     = 0;
         send_gap  = 0;
      end else begin
         // word taken at this edge: predict with the registers in force now
         if (took) begin
            expected_displays.push_back(predict_display(req_ch.scaled_value,
                                                        cfg_places, cfg_mask));
            words_sent <= words_sent + 1;
            nxt_valid = 1'b0;
         end
         // a word taken at this edge is still in flight
         quiet = (words_sent == words_shown && !took) ? quiet + 1 : 0;
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_steps.size() > 0) begin
               head = pending_steps[0];
               calm = head.calm;
               case (head.kind)
                  STEP_WORD: begin
                     if (!calm && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 5);
                     end else begin
                        nxt_valid = 1'b1;
                        nxt_value = head.value;
                        void'(pending_steps.pop_front());
                     end
                  end
                  STEP_CSR: begin
                     // registers only change with the pipe empty and settled
                     if (quiet > SETTLE) begin
                        nxt_we    = 1'b1;
                        nxt_idx   = head.idx;
                        nxt_wdata = head.data;
                        case (head.idx)
                           CSR_DECIMAL_PLACES: cfg_places = dp_type'(head.data);
                           CSR_POINT_MASK:     cfg_mask   = seg_type'(head.data);
                           default:            ;
                        endcase
                        void'(pending_steps.pop_front());
                     end
                  end
                  default: begin
                     // hold off until every expected word is back
                     if (quiet > SETTLE)
                        void'(pending_steps.pop_front());
                  end
               endcase
            end
         end
      end
      req_ch.valid        <= nxt_valid;
      req_ch.scaled_value <= nxt_value;
      csr_write_en        <= nxt_we;
      csr_index           <= nxt_idx;
      csr_write_data      <= nxt_wdata;
   end

   // --------------------------------------------------------------------------
   // monitor: check each result word, stall ready in bursts
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      display_type want;
      logic        nxt_ready;
      nxt_ready = rsp_ch.ready;
      if (reset) begin
         nxt_ready = 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_shown <= words_shown + 1;
            if (expected_displays.size() == 0) begin
               $error("result word with nothing expected: grids %h %h %h %h %h %h shown %b",
                      rsp_ch.grid0, rsp_ch.grid1, rsp_ch.grid2, rsp_ch.grid3,
                      rsp_ch.grid4, rsp_ch.grid5, rsp_ch.shown);
               failed = 1'b1;
            end else begin
               want = expected_displays.pop_front();
               check_field("grid0", want.grid0, rsp_ch.grid0);
               check_field("grid1", want.grid1, rsp_ch.grid1);
               check_field("grid2", want.grid2, rsp_ch.grid2);
               check_field("grid3", want.grid3, rsp_ch.grid3);
               check_field("grid4", want.grid4, rsp_ch.grid4);
               check_field("grid5", want.grid5, rsp_ch.grid5);
               check_field("shown", SEG_W'(want.shown), SEG_W'(rsp_ch.shown));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            nxt_ready = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(0, 5);
            nxt_ready = 1'b0;
         end else begin
            nxt_ready = 1'b1;
         end
      end
      rsp_ch.ready <= nxt_ready;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb_fixed_point_to_seven_segment_unit: FAIL");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin : stimulus
      logic [1:0]            places;
      logic [CSR_DATA_W-1:0] mask;
      // known values on every input from time zero
      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.scaled_value = '0;
      rsp_ch.ready        = 1'b0;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;

      // directed words under the reset registers (three places, point 04)
      push_word(0, 1'b0);                // plain zero, no sign
      push_word(5, 1'b0);                // fraction digits kept as zeros
      push_word(-5, 1'b0);               // minus left of the units digit
      push_word(12, 1'b0);
      push_word(-123, 1'b0);
      push_word(1234, 1'b0);             // one digit above the point
      push_word(-1000, 1'b0);
      push_word(99999, 1'b0);
      push_word(100000, 1'b0);           // full display
      push_word(999998, 1'b0);           // largest shown
      push_word(999999, 1'b0);           // upper limit, rejected
      push_word(1000000, 1'b0);
      push_word(-99998, 1'b0);           // lowest shown, minus in leftmost slot
      push_word(-99999, 1'b0);           // lower limit, rejected
      push_word(-100000, 1'b0);
      push_word(999999999, 1'b0);        // extremes of the random range, rejected
      push_word(-999999999, 1'b0);
      push_word(7, 1'b0);

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         places = 2'(p % 4);
         case (p % 3)
            0:       mask = 8'h00;
            1:       mask = 8'hFF;
            default: mask = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         push_step(STEP_CSR, CSR_DECIMAL_PLACES, CSR_DATA_W'(places));
         push_step(STEP_CSR, CSR_POINT_MASK, mask);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // in phase 4 the sender holds off mid-phase until the pipe has drained
            if (p == 4 && i == PHASE_WORDS / 2)
               push_step(STEP_DRAIN, CSR_DECIMAL_PLACES, '0);
            push_word(random_scaled(), p == PHASES - 1);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver and monitor have settled
      do @(negedge clock);
      while (pending_steps.size() != 0 || req_ch.valid || expected_displays.size() != 0);
      repeat (NUM_STAGES + 4) @(negedge clock);

      if (!failed && expected_displays.size() == 0) begin
         $display("tb_fixed_point_to_seven_segment_unit: PASS");
      end else begin
         $display("tb_fixed_point_to_seven_segment_unit: FAIL");
      end
      $finish;
   end

endmodule
